[src/seven_segment_serial_display_driver_defines.svh]
// Assertion macros shared by the display driver.
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The condition must never hold at a clock edge outside reset.
`define SSD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

// When the antecedent holds, the consequent holds in the same cycle.
`define SSD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define SSD_ASSERT_NEVER(lbl, cond)
`define SSD_ASSERT_IMPLIES(lbl, ante, cons)
`define SSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/ssd_pkg.sv]
package ssd_pkg;

  localparam int VALUE_W        = 15;
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS     = 4;
  localparam int POS_W          = 2;
  localparam int SEG_W          = 8;
  localparam int BITS_PER_DIGIT = 16;
  localparam int BIT_IDX_W      = 4;
  localparam int REFRESH_BITS   = NUM_DIGITS * BITS_PER_DIGIT;
  localparam int CNT_W          = 6;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  // Width of the intermediate remainders after each digit is peeled off.
  localparam int REM4_W = 14;
  localparam int REM3_W = 10;
  localparam int REM2_W = 7;

  localparam logic [VALUE_W-1:0] UNIT_10000 = 15'd10000;
  localparam logic [VALUE_W-1:0] UNIT_1000  = 15'd1000;
  localparam logic [VALUE_W-1:0] UNIT_100   = 15'd100;
  localparam logic [VALUE_W-1:0] UNIT_10    = 15'd10;

  // Segment bytes of one refresh, index 0 is the thousands digit.
  typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] seg_bytes_t;

  typedef struct packed {
    seg_bytes_t seg;
  } refresh_t;

  // Active-low common-anode segment pattern; non-decimal codes blank the digit.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // One-hot digit select, thousands on bit 3 down to units on bit 0.
  function automatic logic [SEG_W-1:0] select_byte(input logic [POS_W-1:0] pos);
    logic [SEG_W-1:0] s;
    case (pos)
      2'd0:    s = 8'h08;
      2'd1:    s = 8'h04;
      2'd2:    s = 8'h02;
      2'd3:    s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Number of whole units in x, capped at nine; the compares are independent.
  function automatic logic [DIGIT_W-1:0] digit_count(input logic [VALUE_W-1:0] x,
                                                     input logic [VALUE_W-1:0] unit);
    logic [DIGIT_W-1:0] cnt;
    cnt = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, x} >= 17'(k) * {2'b00, unit}) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

  // Remainder left after taking d units out of x.
  function automatic logic [VALUE_W-1:0] digit_rem(input logic [VALUE_W-1:0] x,
                                                   input logic [VALUE_W-1:0] unit,
                                                   input logic [DIGIT_W-1:0] d);
    logic [16:0] r;
    r = {2'b00, x} - 17'(d) * {2'b00, unit};
    return r[VALUE_W-1:0];
  endfunction

endpackage

[src/seven_segment_serial_display_driver.sv]
// Four-digit seven-segment serial display driver.
// Input channel (in_*): one beat per refresh request; in_tdata carries the count.
// The low four decimal digits are sent, thousands first, as 64 output beats:
// for each digit 16 bits MSB first, the active-low segment byte and then the
// one-hot digit select byte. Each output beat is one shift clock of the
// external register chain; out_tuser asks for a latch pulse after the 16th bit
// of each digit, and out_tlast marks the 64th bit of the refresh.
// A request passes the three digit stages and the queue before it is shifted.
// Throughput is set by the output shifter, which moves one bit per cycle while
// the receiver takes beats; the three-stage digit pipeline and the two-entry
// queue ahead of it keep taking requests while a refresh is being shifted.
// Reset (rst_n low, synchronous) empties the pipeline, the queue and the
// shifter; nothing is held between refreshes.
// When the receiver holds out_tready low the current beat waits in the output
// register, the shifter pauses, and requests back up through the queue
// until in_tready drops.
`include "seven_segment_serial_display_driver_defines.svh"

module seven_segment_serial_display_driver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [14:0] display_value, [15] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] data_bit, [2:1] digit_position,
                                                        // [7:3] zero
  output logic                              out_tuser,  // [0] latch_after
  output logic                              out_tlast
);
  import ssd_pkg::*;

  logic              push_valid, push_ready;
  refresh_t          push_data;
  logic              take_valid, take_ready;
  refresh_t          take_data;
  logic              data_bit;
  logic [POS_W-1:0]  digit_position;
  logic              beat_done, last_beat, digit_step;

  // Digit extraction and segment mapping.
  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue between digit pipeline and shifter.
  ssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (take_valid),
    .pop_ready  (take_ready),
    .pop_data   (take_data)
  );

  // Serial shifter with registered output beat.
  ssd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .take_valid         (take_valid),
    .take_ready         (take_ready),
    .take_data          (take_data),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_data_bit       (data_bit),
    .out_latch_after    (out_tuser),
    .out_digit_position (digit_position),
    .out_last           (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - POS_W - 1)'(0), digit_position, data_bit};

  // Output beat events watched by the checks below.
  assign beat_done  = out_tvalid && out_tready;
  assign last_beat  = out_tvalid && out_tlast;
  assign digit_step = beat_done && out_tuser && !out_tlast;

  // The final bit of a refresh belongs to the units digit and ends with a latch.
  `SSD_ASSERT_IMPLIES(a_last_is_units_latch, last_beat, out_tuser && digit_position == 2'd3)

  // Within a refresh the shifter never leaves a gap.
  `SSD_ASSERT_NEXT(a_no_gap_in_refresh, beat_done && !out_tlast, out_tvalid)

  // After a latch that is not the last, the next beat moves to the next digit.
  `SSD_ASSERT_NEXT(a_digit_advances, digit_step, digit_position == $past(digit_position) + 2'd1)

endmodule

[src/ssd_front.sv]
module ssd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssd_pkg::VALUE_W-1:0]   in_value,
  output logic                          push_valid,
  input  logic                          push_ready,
  output ssd_pkg::refresh_t             push_data
);
  import ssd_pkg::*;

  logic                    v1_r, v2_r, v3_r;
  logic [REM4_W-1:0]       val1_r;
  logic [REM3_W-1:0]       val2_r;
  logic [REM2_W-1:0]       val3_r;
  logic [DIGIT_W-1:0]      d0_2_r, d0_3_r, d1_3_r;
  logic                    rdy1, rdy2, rdy3;
  logic [DIGIT_W-1:0]      m_cnt, d0, d1, d2;
  logic [VALUE_W-1:0]      m_rem, r0, r1, r2;

  // Each stage moves on when it is empty or its successor is moving.
  assign rdy3     = !v3_r || push_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage one folds the count into 0..9999.
  assign m_cnt = digit_count(in_value, UNIT_10000);
  assign m_rem = digit_rem(in_value, UNIT_10000, m_cnt);

  // Stage two peels off thousands, stage three hundreds.
  assign d0 = digit_count(VALUE_W'(val1_r), UNIT_1000);
  assign r0 = digit_rem(VALUE_W'(val1_r), UNIT_1000, d0);
  assign d1 = digit_count(VALUE_W'(val2_r), UNIT_100);
  assign r1 = digit_rem(VALUE_W'(val2_r), UNIT_100, d1);

  // Last stage splits tens and units and maps all digits to segments.
  assign d2 = digit_count(VALUE_W'(val3_r), UNIT_10);
  assign r2 = digit_rem(VALUE_W'(val3_r), UNIT_10, d2);

  always_comb begin
    push_data.seg[0] = seg_lookup(d0_3_r);
    push_data.seg[1] = seg_lookup(d1_3_r);
    push_data.seg[2] = seg_lookup(d2);
    push_data.seg[3] = seg_lookup(r2[DIGIT_W-1:0]);
  end
  assign push_valid = v3_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      val1_r <= m_rem[REM4_W-1:0];
    end
    if (rdy2 && v1_r) begin
      val2_r <= r0[REM3_W-1:0];
      d0_2_r <= d0;
    end
    if (rdy3 && v2_r) begin
      val3_r <= r1[REM2_W-1:0];
      d0_3_r <= d0_2_r;
      d1_3_r <= d1;
    end
  end

endmodule

[src/ssd_queue.sv]
module ssd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ssd_pkg::refresh_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ssd_pkg::refresh_t pop_data
);
  import ssd_pkg::*;

  refresh_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QPTR_W-1:0]     wr_ptr_nxt, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/ssd_back.sv]
module ssd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take_valid,
  output logic                          take_ready,
  input  ssd_pkg::refresh_t             take_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_data_bit,
  output logic                          out_latch_after,
  output logic [ssd_pkg::POS_W-1:0]     out_digit_position,
  output logic                          out_last
);
  import ssd_pkg::*;

  logic                         active_r, active_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  seg_bytes_t                   seg_r;
  logic                         data_bit_r, latch_r, last_r;
  logic [POS_W-1:0]             pos_r;
  logic                         adv, end_cnt, take;
  logic [POS_W-1:0]             pos;
  logic [BIT_IDX_W-1:0]         bit_idx;
  logic [BITS_PER_DIGIT-1:0]    word;

  // The output register advances when empty or when the receiver takes the beat.
  assign adv        = !out_valid_r || out_ready;
  assign end_cnt    = cnt_r == CNT_W'(REFRESH_BITS - 1);
  assign take_ready = !active_r || (adv && end_cnt);
  assign take       = take_ready && take_valid;

  // Current digit word, sent most significant bit first.
  assign pos     = cnt_r[CNT_W-1 -: POS_W];
  assign bit_idx = cnt_r[BIT_IDX_W-1:0];
  assign word    = {seg_r[pos], select_byte(pos)};

  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = active_r;
      if (active_r) begin
        cnt_nxt = cnt_r + 1'b1;
        if (end_cnt) active_nxt = 1'b0;
      end
    end
    if (take) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Refresh word and output beat payload.
  always_ff @(posedge clk) begin
    if (take) begin
      seg_r <= take_data.seg;
    end
    if (adv && active_r) begin
      data_bit_r <= word[~bit_idx];
      latch_r    <= &bit_idx;
      pos_r      <= pos;
      last_r     <= end_cnt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_bit       = data_bit_r;
  assign out_latch_after    = latch_r;
  assign out_digit_position = pos_r;
  assign out_last           = last_r;

endmodule

[test/ssd_shift_checker.sv]
// Watches both channels of the display driver, works out the 64 shift beats
// that each refresh request should produce and compares every output beat
// against the oldest beat still owed.
module ssd_shift_checker
  import ssd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  output int unsigned            mismatches,
  output int unsigned            bits_owed
);

  typedef struct packed {
    logic             data_bit;
    logic             latch_after;
    logic [POS_W-1:0] digit_position;
    logic             last;
  } shift_beat_t;

  shift_beat_t owed_beats[$];
  int unsigned beat_index = 0;

  // Active-low common-anode glyph for one decimal digit.
  function automatic logic [SEG_W-1:0] glyph_for(input int unsigned digit);
    logic [SEG_W-1:0] g;
    case (digit)
      0:       g = 8'hC0;
      1:       g = 8'hF9;
      2:       g = 8'hA4;
      3:       g = 8'hB0;
      4:       g = 8'h99;
      5:       g = 8'h92;
      6:       g = 8'h82;
      7:       g = 8'hF8;
      8:       g = 8'h80;
      9:       g = 8'h90;
      default: g = 8'hFF;
    endcase
    return g;
  endfunction

  // Queue the serial stream for one count: four digits, thousands first,
  // each as the glyph byte then the one-hot select byte, MSB first.
  task automatic queue_refresh(input logic [VALUE_W-1:0] count);
    int unsigned shown;
    int unsigned scale;
    logic [15:0] word;
    shift_beat_t beat;
    shown = int'(count) % 10000;
    scale = 1000;
    for (int pos = 0; pos < NUM_DIGITS; pos++) begin
      word = {glyph_for((shown / scale) % 10), 8'h08 >> pos};
      for (int b = 0; b < BITS_PER_DIGIT; b++) begin
        beat.data_bit       = word[BITS_PER_DIGIT-1-b];
        beat.latch_after    = (b == BITS_PER_DIGIT - 1);
        beat.digit_position = POS_W'(pos);
        beat.last           = (pos == NUM_DIGITS - 1) && (b == BITS_PER_DIGIT - 1);
        owed_beats.push_back(beat);
      end
      scale = scale / 10;
    end
  endtask

  // One line per mismatch.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at output beat %0d: %s got %0d, expected %0d",
             beat_index, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // Requests are queued before output beats are checked in the same cycle.
  always @(posedge clk) begin
    shift_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        queue_refresh(in_tdata[VALUE_W-1:0]);
      end
      if (out_tvalid && out_tready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("beat with nothing owed, tdata", out_tdata, 0);
        end else begin
          want = owed_beats.pop_front();
          if (out_tdata[0] !== want.data_bit) begin
            report_mismatch("data_bit", out_tdata[0], want.data_bit);
          end
          if (out_tuser !== want.latch_after) begin
            report_mismatch("latch_after", out_tuser, want.latch_after);
          end
          if (out_tdata[2:1] !== want.digit_position) begin
            report_mismatch("digit_position", out_tdata[2:1], want.digit_position);
          end
          if (out_tlast !== want.last) begin
            report_mismatch("last", out_tlast, want.last);
          end
        end
        beat_index = beat_index + 1;
      end
    end
    bits_owed <= owed_beats.size();
  end

endmodule

[test/seven_segment_serial_display_driver_tb.sv]
// Stimulus and verdict for the display driver; the beat-by-beat checking lives in the
// checker instance beside the block.
module seven_segment_serial_display_driver_tb;
  import ssd_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES  = 32;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int unsigned mismatches;
  int unsigned bits_owed;
  int unsigned cycle_count = 0;

  // Idle and stall rates in percent, and the hold-off request handshake.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_served = 0;
  int unsigned holdoff_left = 0;

  always #5 clk = ~clk;

  seven_segment_serial_display_driver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ssd_shift_checker bit_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .bits_owed  (bits_owed)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: a requested hold-off keeps tready low for a long stretch,
  // otherwise tready stalls at the current rate.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_tready   <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_asked != holdoff_served) begin
      out_tready     <= 1'b0;
      holdoff_left   <= HOLDOFF_CYCLES - 1;
      holdoff_served <= holdoff_asked;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Counts biased toward digit boundaries, wrap points, repeated digits and the top of range.
  function automatic logic [VALUE_W-1:0] pick_count();
    int unsigned v;
    case ($urandom_range(5))
      0, 1, 2: v = $urandom_range(32767);
      3:       v = 10000 * $urandom_range(1, 3) - 5 + $urandom_range(10);
      4:       v = 1111 * $urandom_range(9);
      default: v = 32767 - $urandom_range(15);
    endcase
    return VALUE_W'(v);
  endfunction

  // Offer one request beat and wait for it to be taken, then maybe go idle.
  task automatic send_word(input logic [IN_TDATA_W-1:0] word);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed beat has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bits_owed != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned sender_idle, input int unsigned receiver_stall,
                           input int unsigned count, input bit hold_receiver);
    idle_pct = sender_idle;
    stall_pct <= receiver_stall;
    if (hold_receiver) begin
      holdoff_asked <= holdoff_asked + 1;
    end
    repeat (count) send_word({1'b0, pick_count()});
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed counts: varied digits in every position, digit boundaries,
    // counts of 10000 and above, the top of range, and a set pad bit.
    send_word(16'd0);
    send_word(16'd1);
    send_word(16'd10);
    send_word(16'd100);
    send_word(16'd1000);
    send_word(16'd1234);
    send_word(16'd5678);
    send_word(16'd9012);
    send_word(16'd3456);
    send_word(16'd7890);
    send_word(16'd6789);
    send_word(16'd9999);
    send_word(16'd10000);
    send_word(16'd10001);
    send_word(16'd19999);
    send_word(16'd20000);
    send_word(16'd29999);
    send_word(16'd30000);
    send_word(16'd32767);
    send_word({1'b1, 15'd4321});
    send_word({1'b1, 15'd32767});
    drain();

    // Random phases; the first one also holds the receiver off for a long
    // stretch so the request side backs up.
    run_phase(0, 0, 85, 1'b1);
    run_phase(73, 0, 85, 1'b0);
    run_phase(0, 73, 85, 1'b0);
    run_phase(8, 8, 85, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && bits_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ssd_pkg.sv
src/ssd_front.sv
src/ssd_queue.sv
src/ssd_back.sv
src/seven_segment_serial_display_driver.sv
test/ssd_shift_checker.sv
test/seven_segment_serial_display_driver_tb.sv
